### design/tcp_pkg.sv
package tcp_pkg;

  typedef enum logic [1:0] {
    OP_RULE     = 2'd0,
    OP_CLEAR    = 2'd1,
    OP_COLLAPSE = 2'd2,
    OP_READ     = 2'd3
  } op_e;

  typedef enum logic [0:0] {
    CFG_MAP_SIZE   = 1'b0,
    CFG_TYPE_COUNT = 1'b1
  } cfg_idx_e;

  localparam int unsigned OUT_MASK_W = 16;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [5:0]  cell_x;
    logic [5:0]  cell_y;
    logic [3:0]  tile_type;
    logic [1:0]  direction;
    logic [15:0] rule_mask;
  } in_item_t;

  typedef struct packed {
    logic [15:0] cell_mask;
    logic        cell_closed;
    logic        open_cells_left;
    logic        contradiction;
  } out_item_t;

  // classified command handed from front to back
  typedef struct packed {
    op_e         op;
    logic        in_map;
    logic        type_ok;
    logic [5:0]  x;
    logic [5:0]  y;
    logic [3:0]  t;
    logic [1:0]  d;
    logic [15:0] rm;
  } cmd_t;

endpackage

### design/tcp_front.sv
module tcp_front import tcp_pkg::*; #(
  parameter int SW = 7
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [SW-1:0] side_i,
  input  logic [4:0]    types_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  in_item_t      in_item_i,
  output logic          push_o,
  input  logic          push_ready_i,
  output cmd_t          cmd_o
);

  logic seen_q;

  assign in_ready_o = push_ready_i;
  assign push_o     = in_valid_i && push_ready_i;

  always_comb begin
    cmd_o.op      = op_e'(in_item_i.opcode);
    cmd_o.in_map  = (32'(in_item_i.cell_x) < 32'(side_i)) &&
                    (32'(in_item_i.cell_y) < 32'(side_i));
    cmd_o.type_ok = 32'(in_item_i.tile_type) < 32'(types_i);
    cmd_o.x       = in_item_i.cell_x;
    cmd_o.y       = in_item_i.cell_y;
    cmd_o.t       = in_item_i.tile_type;
    cmd_o.d       = in_item_i.direction;
    cmd_o.rm      = in_item_i.rule_mask;
  end

  // tracks whether any transaction has been taken since reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= 1'b0;
    end else if (push_o) begin
      seen_q <= 1'b1;
    end
  end

  a_push_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> push_ready_i && in_valid_i) else $error("push without room");
  a_seen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |=> seen_q) else $error("seen flag lost");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !push_ready_i |-> !push_o) else $error("push while full");

endmodule

### design/tcp_fifo.sv
module tcp_fifo import tcp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  output logic push_ready_o,
  input  cmd_t push_data_i,
  output logic pop_valid_o,
  input  logic pop_i,
  output cmd_t pop_data_o
);

  cmd_t       buf_q [2];
  logic       wp_q, wp_d, rp_q, rp_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign push_ready_o = cnt_q != 2'd2;
  assign pop_valid_o  = cnt_q != 2'd0;
  assign pop_data_o   = buf_q[rp_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  always_comb begin
    wp_d  = do_push ? ~wp_q : wp_q;
    rp_d  = do_pop ? ~rp_q : rp_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      buf_q[wp_q] <= push_data_i;
    end
  end

  a_cnt_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0 || cnt_q == 2'd2) |-> wp_q == rp_q) else $error("pointer mismatch");
  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("fill count overflow");
  a_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd1 |-> wp_q != rp_q) else $error("pointer mismatch");

endmodule

### design/tcp_engine.sv
module tcp_engine import tcp_pkg::*; #(
  parameter int MAX_DIM   = 64,
  parameter int TYPE_BITS = 16,
  parameter int SW        = 7
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [SW-1:0] side_i,
  input  logic [4:0]    types_i,
  input  logic          cmd_valid_i,
  output logic          cmd_ready_o,
  input  cmd_t          cmd_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output out_item_t     out_item_o
);

  localparam int NT    = (TYPE_BITS < 16) ? TYPE_BITS : 16;
  localparam int TW    = $clog2(NT);
  localparam int XW    = $clog2(MAX_DIM);
  localparam int CELLS = MAX_DIM * MAX_DIM;
  localparam int CW    = $clog2(CELLS);
  localparam int WW    = NT + 2;
  localparam int PB    = NT + 1;
  localparam int CB    = NT;

  typedef enum logic [12:0] {
    S_CLR      = 13'b0000000000001,
    S_IDLE     = 13'b0000000000010,
    S_COL_RD   = 13'b0000000000100,
    S_COL_CHK  = 13'b0000000001000,
    S_UNION    = 13'b0000000010000,
    S_NB_RD    = 13'b0000000100000,
    S_NB_MOD   = 13'b0000001000000,
    S_SCAN_RD  = 13'b0000010000000,
    S_SCAN_CHK = 13'b0000100000000,
    S_CNT      = 13'b0001000000000,
    S_CNT_END  = 13'b0010000000000,
    S_RES_RD   = 13'b0100000000000,
    S_RES      = 13'b1000000000000
  } state_e;

  state_e          state_q, state_d;
  cmd_t            cmd_q, cmd_d;
  logic            init_q, init_d;
  logic            empty_q, empty_d;
  logic            open_any_q, open_any_d;
  logic            cnt_v_q, cnt_v_d;
  logic            any_q, any_d;
  logic            drain_q, drain_d;
  logic [XW-1:0]   sx_q, sx_d, sy_q, sy_d, cx_q, cx_d, cy_q, cy_d;
  logic [1:0]      dir_q, dir_d;
  logic [NT-1:0]   own_q, own_d;
  logic [NT-1:0]   u_q [4];
  logic [NT-1:0]   u_d [4];
  logic [CW-1:0]   clr_q, clr_d;
  logic [WW-1:0]   rdata_q;
  logic [WW-1:0]   mem [CELLS];
  out_item_t       out_q, out_d;
  logic            out_valid_q, out_valid_d;
  logic [NT-1:0]   rule_q [4][NT];

  logic            mem_we, mem_re;
  logic [CW-1:0]   mem_addr;
  logic [WW-1:0]   mem_wdata;
  logic            res_load, rule_we;
  logic [NT-1:0]   used_mask, onehot, newm;
  logic            last_x, last_y, at_end;
  logic [XW-1:0]   scan_nx, scan_ny, nbx, nby;
  logic            nb_ok;

  function automatic logic [CW-1:0] cell_addr(logic [XW-1:0] x, logic [XW-1:0] y);
    cell_addr = CW'(32'(y) * MAX_DIM + 32'(x));
  endfunction

  always_comb begin
    for (int i = 0; i < NT; i++) begin
      used_mask[i] = 32'(i) < 32'(types_i);
      onehot[i]    = 32'(i) == 32'(cmd_q.t);
    end
  end

  assign last_x  = sx_q == XW'(side_i - 1'b1);
  assign last_y  = sy_q == XW'(side_i - 1'b1);
  assign at_end  = last_x && last_y;
  assign scan_nx = last_x ? '0 : XW'(sx_q + 1'b1);
  assign scan_ny = last_x ? XW'(sy_q + 1'b1) : sy_q;
  assign newm    = rdata_q[NT-1:0] & u_q[dir_q];

  // neighbour of the spreading cell in the current direction
  always_comb begin
    nbx   = cx_q;
    nby   = cy_q;
    nb_ok = 1'b0;
    case (dir_q)
      2'd0: begin
        nb_ok = cy_q != '0;
        nby   = XW'(cy_q - 1'b1);
      end
      2'd1: begin
        nb_ok = (32'(cx_q) + 1) < 32'(side_i);
        nbx   = XW'(cx_q + 1'b1);
      end
      2'd2: begin
        nb_ok = (32'(cy_q) + 1) < 32'(side_i);
        nby   = XW'(cy_q + 1'b1);
      end
      default: begin
        nb_ok = cx_q != '0;
        nbx   = XW'(cx_q - 1'b1);
      end
    endcase
  end

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    init_d      = init_q;
    empty_d     = empty_q;
    open_any_d  = open_any_q;
    cnt_v_d     = 1'b0;
    any_d       = any_q;
    drain_d     = drain_q;
    sx_d        = sx_q;
    sy_d        = sy_q;
    cx_d        = cx_q;
    cy_d        = cy_q;
    dir_d       = dir_q;
    own_d       = own_q;
    clr_d       = clr_q;
    for (int d = 0; d < 4; d++) begin
      u_d[d] = u_q[d];
    end
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_addr    = cell_addr(sx_q, sy_q);
    mem_wdata   = rdata_q;
    cmd_ready_o = 1'b0;
    res_load    = 1'b0;
    rule_we     = 1'b0;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;

    unique case (state_q)
      S_CLR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_q;
        mem_wdata = {1'b0, 1'b0, used_mask};
        clr_d     = CW'(clr_q + 1'b1);
        if (clr_q == CW'(CELLS - 1)) begin
          clr_d      = '0;
          empty_d    = 1'b0;
          init_d     = 1'b0;
          sx_d       = '0;
          sy_d       = '0;
          open_any_d = 1'b0;
          state_d    = init_q ? S_IDLE : S_CNT;
        end
      end
      S_IDLE: begin
        if (cmd_valid_i && !init_q) begin
          cmd_ready_o = 1'b1;
          cmd_d       = cmd_i;
          cx_d        = XW'(cmd_i.x);
          cy_d        = XW'(cmd_i.y);
          sx_d        = '0;
          sy_d        = '0;
          open_any_d  = 1'b0;
          state_d     = S_CNT;
          unique case (cmd_i.op)
            OP_RULE:     rule_we = 1'b1;
            OP_CLEAR:    state_d = S_CLR;
            OP_COLLAPSE: if (cmd_i.in_map && cmd_i.type_ok) state_d = S_COL_RD;
            default:     state_d = S_CNT;
          endcase
        end
      end
      S_COL_RD: begin
        mem_re   = 1'b1;
        mem_addr = cell_addr(cx_q, cy_q);
        state_d  = S_COL_CHK;
      end
      S_COL_CHK: begin
        if (rdata_q[CB]) begin
          sx_d       = '0;
          sy_d       = '0;
          open_any_d = 1'b0;
          state_d    = S_CNT;
        end else begin
          mem_we    = 1'b1;
          mem_addr  = cell_addr(cx_q, cy_q);
          mem_wdata = {1'b0, 1'b1, onehot};
          own_d     = onehot;
          drain_d   = 1'b0;
          state_d   = S_UNION;
        end
      end
      S_UNION: begin
        for (int d = 0; d < 4; d++) begin
          u_d[d] = '0;
          for (int b = 0; b < NT; b++) begin
            if (own_q[b]) u_d[d] = u_d[d] | rule_q[d][b];
          end
        end
        dir_d   = 2'd0;
        state_d = S_NB_RD;
      end
      S_NB_RD, S_NB_MOD: begin
        mem_addr = cell_addr(nbx, nby);
        if (state_q == S_NB_RD && nb_ok) begin
          mem_re  = 1'b1;
          state_d = S_NB_MOD;
        end else begin
          if (state_q == S_NB_MOD && !rdata_q[CB] && newm != rdata_q[NT-1:0]) begin
            mem_we    = 1'b1;
            mem_wdata = {1'b1, 1'b0, newm};
            if (newm == '0) empty_d = 1'b1;
          end
          if (dir_q != 2'd3) begin
            dir_d   = dir_q + 2'd1;
            state_d = S_NB_RD;
          end else if (!drain_q) begin
            drain_d = 1'b1;
            any_d   = 1'b0;
            sx_d    = '0;
            sy_d    = '0;
            state_d = S_SCAN_RD;
          end else if (!at_end) begin
            sx_d    = scan_nx;
            sy_d    = scan_ny;
            state_d = S_SCAN_RD;
          end else begin
            // a cell was handled this sweep, so sweep again
            sx_d    = '0;
            sy_d    = '0;
            any_d   = 1'b0;
            state_d = S_SCAN_RD;
          end
        end
      end
      S_SCAN_RD: begin
        mem_re  = 1'b1;
        state_d = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (rdata_q[PB]) begin
          mem_we    = 1'b1;
          mem_wdata = {1'b0, rdata_q[CB:0]};
          any_d     = 1'b1;
        end
        if (rdata_q[PB] && !rdata_q[CB]) begin
          own_d   = rdata_q[NT-1:0];
          cx_d    = sx_q;
          cy_d    = sy_q;
          state_d = S_UNION;
        end else if (!at_end) begin
          sx_d    = scan_nx;
          sy_d    = scan_ny;
          state_d = S_SCAN_RD;
        end else begin
          sx_d  = '0;
          sy_d  = '0;
          any_d = 1'b0;
          if (any_q || rdata_q[PB]) begin
            state_d = S_SCAN_RD;
          end else begin
            open_any_d = 1'b0;
            state_d    = S_CNT;
          end
        end
      end
      S_CNT: begin
        mem_re  = 1'b1;
        cnt_v_d = 1'b1;
        if (cnt_v_q && !rdata_q[CB]) open_any_d = 1'b1;
        if (at_end) begin
          state_d = S_CNT_END;
        end else begin
          sx_d = scan_nx;
          sy_d = scan_ny;
        end
      end
      S_CNT_END: begin
        if (!rdata_q[CB]) open_any_d = 1'b1;
        state_d = S_RES_RD;
      end
      S_RES_RD: begin
        mem_re   = 1'b1;
        mem_addr = cell_addr(XW'(cmd_q.x), XW'(cmd_q.y));
        state_d  = S_RES;
      end
      S_RES: begin
        if (!out_valid_q || out_ready_i) begin
          res_load                = 1'b1;
          out_valid_d             = 1'b1;
          out_d.cell_mask         = cmd_q.in_map ? OUT_MASK_W'(rdata_q[NT-1:0]) : '0;
          out_d.cell_closed       = cmd_q.in_map && rdata_q[CB];
          out_d.open_cells_left   = open_any_q;
          out_d.contradiction     = empty_q;
          state_d                 = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      init_q      <= 1'b1;
      empty_q     <= 1'b0;
      open_any_q  <= 1'b0;
      cnt_v_q     <= 1'b0;
      any_q       <= 1'b0;
      drain_q     <= 1'b0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      init_q      <= init_d;
      empty_q     <= empty_d;
      open_any_q  <= open_any_d;
      cnt_v_q     <= cnt_v_d;
      any_q       <= any_d;
      drain_q     <= drain_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    sx_q  <= sx_d;
    sy_q  <= sy_d;
    cx_q  <= cx_d;
    cy_q  <= cy_d;
    dir_q <= dir_d;
    own_q <= own_d;
    out_q <= out_d;
    for (int d = 0; d < 4; d++) begin
      u_q[d] <= u_d[d];
    end
    if (rule_we && 32'(cmd_i.t) < NT) begin
      rule_q[cmd_i.d][TW'(cmd_i.t)] <= NT'(cmd_i.rm);
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rdata_q <= mem[mem_addr];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_cnt_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CNT || state_q == S_CNT_END) |-> !mem_we)
    else $error("cell store written during open count");
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load |-> (!out_valid_q || out_ready_i)) else $error("result overwritten");
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_ready_o |-> (state_q == S_IDLE) && !init_q) else $error("command taken while busy");
  a_clear_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLR && clr_q == CW'(CELLS - 1)) |=> !empty_q)
    else $error("contradiction flag survived clear");

endmodule

### design/tile_constraint_propagator.sv
// Channel  Direction  Handshake               Payload
// in       input      in_valid_i/in_ready_o   in_item_i   (in_item_t)
// out      output     out_valid_o/out_ready_i out_item_o  (out_item_t)
// cfg      input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// After reset a clearing pass writes all MAX_DIM*MAX_DIM cells, one per cycle, before the
// first command is taken. Every command ends with an open-cell count over the N*N map
// and a read of the addressed cell. Clear adds a fill of all MAX_DIM*MAX_DIM cells.
// Collapse adds worklist sweeps over the map plus a neighbour update per spreading cell;
// the single cell-store port serialises this work. A two-entry command queue keeps
// accepting while the engine works or the result waits, until both entries are full.
module tile_constraint_propagator import tcp_pkg::*; #(
  parameter int MAX_DIM   = 64,
  parameter int TYPE_BITS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic      cfg_index_i,
  input  logic [6:0] cfg_data_i
);

  localparam int NT = (TYPE_BITS < 16) ? TYPE_BITS : 16;
  localparam int SW = $clog2(MAX_DIM + 1);

  logic [6:0]    map_size_q;
  logic [4:0]    type_count_q;
  logic [SW-1:0] side;
  logic [4:0]    types;
  logic          push, push_ready, pop, pop_valid;
  cmd_t          push_cmd, pop_cmd;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_size_q   <= 7'd64;
      type_count_q <= 5'd16;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_MAP_SIZE:   map_size_q   <= cfg_data_i;
        default:        type_count_q <= cfg_data_i[4:0];
      endcase
    end
  end

  always_comb begin
    if (map_size_q == '0) begin
      side = SW'(1);
    end else if (32'(map_size_q) > MAX_DIM) begin
      side = SW'(MAX_DIM);
    end else begin
      side = SW'(map_size_q);
    end
    if (type_count_q == '0) begin
      types = 5'd1;
    end else if (32'(type_count_q) > NT) begin
      types = 5'(NT);
    end else begin
      types = type_count_q;
    end
  end

  tcp_front #(.SW(SW)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .side_i       (side),
    .types_i      (types),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_item_i    (in_item_i),
    .push_o       (push),
    .push_ready_i (push_ready),
    .cmd_o        (push_cmd)
  );

  tcp_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (push_ready),
    .push_data_i  (push_cmd),
    .pop_valid_o  (pop_valid),
    .pop_i        (pop),
    .pop_data_o   (pop_cmd)
  );

  tcp_engine #(
    .MAX_DIM   (MAX_DIM),
    .TYPE_BITS (TYPE_BITS),
    .SW        (SW)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .side_i      (side),
    .types_i     (types),
    .cmd_valid_i (pop_valid),
    .cmd_ready_o (pop),
    .cmd_i       (pop_cmd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule
